// ===== src/dhmt_pkg.sv =====
// Types and codes shared by the double-hashing multiset table.
package dhmt_pkg;

   localparam int KEY_W   = 32;
   localparam int BIT_W   = $clog2(KEY_W);
   localparam int COUNT_W = 11;
   localparam int OCC_W   = 10;
   localparam int TOTAL_W = 10;

   typedef logic [1:0] status_type;
   localparam status_type ST_EMPTY   = 2'd0;
   localparam status_type ST_USED    = 2'd1;
   localparam status_type ST_DELETED = 2'd2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;
   localparam mode_type MODE_SEARCH = 2'd2;
   localparam mode_type MODE_COUNT  = 2'd3;

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] key;
   } slot_type;

   // Unsigned magnitude of a two's complement key; the most negative key maps to 2^31.
   function automatic logic [KEY_W-1:0] key_magnitude(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] m;
      m = k[KEY_W-1] ? (~k) + KEY_W'(1) : k;
      return m;
   endfunction

endpackage

// ===== src/double_hash_multiset_table.sv =====
// Double-hashing multiset table: open-addressed slot memory with sequential probe engine.
//
// Usage:
//   Request channel: drive req_mode and req_key and raise start; the word is taken at the
//   rising edge where start is high and busy is low. Modes: insert, remove, search, count.
//   Result channel: rsp_valid strobes for exactly one cycle with rsp_success,
//   rsp_table_full, rsp_occurrences and rsp_element_total. The receiver cannot stall, so each
//   result is gone after its single cycle; busy is low then unless a sweep starts.
// Sequence:
//   Hash phases (quotient, remainder, fold) derive start slot and probe step (reciprocal
//   multiply for the quotients, a remainder below twice the modulus, one correcting
//   subtract), then one probe per cycle out of the slot memory (one write port, registered
//   read port, data valid in the cycle after the address). A word finishing at probe p
//   raises its registered strobe after that probe is evaluated; remove always walks all N
//   slots unless it hits first. The next word is taken only once busy is low again, so the
//   probe walk sets the rate.
// Reset:
//   Synchronous reset starts a clearing pass that writes every slot empty, one slot a
//   cycle, with busy high. A remove that misses while the element count is zero strobes
//   its result as it enters the same pass, which also sweeps tombstones.
module double_hash_multiset_table
   import dhmt_pkg::*;
#(
   parameter int TABLE_SLOTS = 1021
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                  rsp_valid,
   output logic                  rsp_success,
   output logic                  rsp_table_full,
   output logic [OCC_W-1:0]      rsp_occurrences,
   output logic [TOTAL_W-1:0]    rsp_element_total
);

   localparam int ADDR_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam logic [ADDR_W:0]   SLOTS_EXT  = (ADDR_W + 1)'(TABLE_SLOTS);
   localparam logic [ADDR_W:0]   STEPS_EXT  = (ADDR_W + 1)'(TABLE_SLOTS - 1);
   localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0]  PROBES     = CNT_W'(TABLE_SLOTS);
   localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);

   // Reciprocals floor(2^32 / d) for the start slot and the probe step
   localparam logic [2*KEY_W-1:0] RADIX  = (2*KEY_W)'(1) << KEY_W;
   localparam logic [KEY_W-1:0]   RECIP1 = KEY_W'(RADIX / (2*KEY_W)'(TABLE_SLOTS));
   localparam logic [KEY_W-1:0]   RECIP2 = KEY_W'(RADIX / (2*KEY_W)'(TABLE_SLOTS - 1));

   // Hash phases
   localparam logic [BIT_W-1:0]  PH_QUOT    = BIT_W'(0);
   localparam logic [BIT_W-1:0]  PH_REM     = BIT_W'(1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_HASH  = 2'd2;
   localparam logic [1:0] S_PROBE = 2'd3;

   // Quotient estimate, never above the true quotient and at most one below it.
   function automatic logic [KEY_W-1:0] quot_est(input logic [KEY_W-1:0] m,
                                                 input logic [KEY_W-1:0] recip);
      logic [2*KEY_W-1:0] p;
      p = (2*KEY_W)'(m) * (2*KEY_W)'(recip);
      return p[2*KEY_W-1:KEY_W];
   endfunction

   // Remainder left by the estimate; below twice the modulus.
   function automatic logic [ADDR_W:0] rem_est(input logic [KEY_W-1:0] m,
                                               input logic [KEY_W-1:0] q,
                                               input logic [ADDR_W:0] d);
      logic [KEY_W-1:0] t;
      t = m - q * KEY_W'(d);
      return t[ADDR_W:0];
   endfunction

   // Subtract the modulus once if it still fits.
   function automatic logic [ADDR_W-1:0] fold_once(input logic [ADDR_W:0] t,
                                                   input logic [ADDR_W:0] d);
      return (t >= d) ? ADDR_W'(t - d) : t[ADDR_W-1:0];
   endfunction

   // Control state
   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               dlast_ff, dlast_in;
   logic [ADDR_W-1:0]  dpos_ff, dpos_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-word payload
   mode_type           mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   mag_ff, mag_in;
   logic [KEY_W-1:0]   q1_ff, q1_in;
   logic [KEY_W-1:0]   q2_ff, q2_in;
   logic [ADDR_W:0]    t1_ff, t1_in;
   logic [ADDR_W:0]    t2_ff, t2_in;
   logic [ADDR_W-1:0]  r1_ff, r1_in;
   logic [ADDR_W-1:0]  r2_ff, r2_in;
   logic               succ_ff, succ_in;
   logic               full_ff, full_in;
   logic [OCC_W-1:0]   rocc_ff, rocc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // Slot memory
   slot_type           slot_mem [TABLE_SLOTS];
   slot_type           rd_data_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   slot_type           wr_data;

   // Probe evaluation
   logic [ADDR_W-1:0]  step;
   logic [ADDR_W:0]    pos_sum;
   logic [ADDR_W-1:0]  pos_next;
   logic               is_used;
   logic               is_empty;
   logic               key_hit;
   logic               issue;
   logic               done;

   assign step     = r2_ff + ADDR_W'(1);
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step};
   assign pos_next = (pos_sum >= SLOTS_EXT) ? ADDR_W'(pos_sum - SLOTS_EXT)
                                            : pos_sum[ADDR_W-1:0];
   assign is_used  = (rd_data_ff.status == ST_USED);
   assign is_empty = (rd_data_ff.status == ST_EMPTY);
   assign key_hit  = is_used && (rd_data_ff.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      iss_in       = iss_ff;
      bit_in       = bit_ff;
      rd_vld_in    = 1'b0;
      dlast_in     = (iss_ff == LAST_PROBE);
      dpos_in      = pos_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      rsp_valid_in = 1'b0;
      mode_in      = mode_ff;
      key_in       = key_ff;
      mag_in       = mag_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      succ_in      = succ_ff;
      full_in      = full_ff;
      rocc_in      = rocc_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_addr      = dpos_ff;
      wr_data      = '{status: ST_USED, key: key_ff};
      issue        = 1'b0;
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_HASH;
               mode_in  = req_mode;
               key_in   = req_key;
               mag_in   = key_magnitude(req_key);
               r1_in    = '0;
               r2_in    = '0;
               bit_in   = '0;
               occ_in   = '0;
            end
         end
         S_SWEEP: begin
            // clear one slot a cycle
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = '{status: ST_EMPTY, key: '0};
            pos_in  = pos_ff + ADDR_W'(1);
            if (pos_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_HASH: begin
            // estimate quotients, then remainders, then fold each remainder once
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == PH_QUOT) begin
               q1_in = quot_est(mag_ff, RECIP1);
               q2_in = quot_est(mag_ff, RECIP2);
            end else if (bit_ff == PH_REM) begin
               t1_in = rem_est(mag_ff, q1_ff, SLOTS_EXT);
               t2_in = rem_est(mag_ff, q2_ff, STEPS_EXT);
            end else begin
               r1_in    = fold_once(t1_ff, SLOTS_EXT);
               r2_in    = fold_once(t2_ff, STEPS_EXT);
               state_in = S_PROBE;
               pos_in   = r1_in;
               iss_in   = '0;
            end
         end
         S_PROBE: begin
            if (rd_vld_ff) begin
               unique case (mode_ff)
                  MODE_INSERT: begin
                     if (!is_used) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + COUNT_W'(1);
                        succ_in  = 1'b1;
                        full_in  = 1'b0;
                        done     = 1'b1;
                     end else if (dlast_ff) begin
                        succ_in = 1'b0;
                        full_in = 1'b1;
                        done    = 1'b1;
                     end
                     rocc_in = '0;
                  end
                  MODE_REMOVE: begin
                     full_in = 1'b0;
                     rocc_in = '0;
                     if (key_hit) begin
                        wr_en    = 1'b1;
                        wr_data  = '{status: ST_DELETED, key: key_ff};
                        count_in = count_ff - COUNT_W'(1);
                        succ_in  = 1'b1;
                        done     = 1'b1;
                     end else if (dlast_ff) begin
                        succ_in = 1'b0;
                        done    = 1'b1;
                     end
                  end
                  MODE_SEARCH: begin
                     full_in = 1'b0;
                     rocc_in = '0;
                     succ_in = key_hit;
                     done    = key_hit || is_empty || dlast_ff;
                  end
                  MODE_COUNT: begin
                     full_in = 1'b0;
                     occ_in  = occ_ff + OCC_W'(key_hit);
                     rocc_in = occ_in;
                     succ_in = (occ_in != '0);
                     done    = is_empty || dlast_ff;
                  end
               endcase
            end

            // keep one read in flight ahead of the evaluation
            issue = (iss_ff != PROBES) && !done;
            if (issue) begin
               pos_in = pos_next;
               iss_in = iss_ff + CNT_W'(1);
            end
            rd_vld_in = issue;

            if (done) begin
               rsp_valid_in = 1'b1;
               total_in     = count_in[TOTAL_W-1:0];
               if ((mode_ff == MODE_REMOVE) && !key_hit && (count_ff == '0)) begin
                  state_in = S_SWEEP;
                  pos_in   = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         pos_ff       <= '0;
         iss_ff       <= '0;
         bit_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         iss_ff       <= iss_in;
         bit_ff       <= bit_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dlast_ff <= dlast_in;
      dpos_ff  <= dpos_in;
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      mag_ff   <= mag_in;
      q1_ff    <= q1_in;
      q2_ff    <= q2_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      succ_ff  <= succ_in;
      full_ff  <= full_in;
      rocc_ff  <= rocc_in;
      total_ff <= total_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = succ_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_occurrences   = rocc_ff;
   assign rsp_element_total = total_ff;

   // A full table never reports a successful insert.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_success)
      else $error("table_full reported with success");

   // Nonzero occurrence count always comes with success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_occurrences != '0) |-> rsp_success)
      else $error("occurrences without success");

   // An accepted word holds the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // Read data is only in flight during the probe walk.
   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_PROBE))
      else $error("slot read outstanding outside probe walk");

endmodule
